FILE: design/hpm_pkg.sv
// Shared types and constants of the homography point mapper.
`default_nettype none

package hpm_pkg;

   // Q32.32 sums of three products need 66 bits with sign.
   localparam int SUM_W = 66;
   // Magnitude of such a sum always fits in 64 bits.
   localparam int MAG_W = 64;
   // Numerator magnitude shifted left by FRAC_SHIFT for a rounded Q20.12 quotient.
   localparam int FRAC_SHIFT = 13;
   localparam int NUM_W = MAG_W + FRAC_SHIFT;
   // Q12.20 offset times Q20.12 one gives Q32.32.
   localparam int COEF_ALIGN = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] DMIN_RESET = 32'd4295;

   localparam logic [2:0] CSR_PAIR_A = 3'd0;
   localparam logic [2:0] CSR_PAIR_B = 3'd1;
   localparam logic [2:0] CSR_PAIR_C = 3'd2;
   localparam logic [2:0] CSR_PAIR_D = 3'd3;
   localparam logic [2:0] CSR_LAST   = 3'd4;
   localparam logic [2:0] CSR_SIDE   = 3'd5;
   localparam logic [2:0] CSR_DMIN   = 3'd6;

   localparam logic [1:0] SIDE_NOT_READY = 2'd0;
   localparam logic [1:0] SIDE_ANY       = 2'd1;
   localparam logic [1:0] SIDE_POS       = 2'd2;
   localparam logic [1:0] SIDE_NEG       = 2'd3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_READY = 3'd1,
      ST_NEAR_ZERO = 3'd2,
      ST_WRONG_SIDE = 3'd3,
      ST_RANGE     = 3'd4
   } hpm_status_type;

   typedef struct packed {
      logic [NUM_W-1:0] n_x;
      logic [NUM_W-1:0] n_y;
      logic [MAG_W-1:0] d;
      logic             neg_x;
      logic             neg_y;
      hpm_status_type   status;
   } hpm_entry_type;

   typedef struct packed {
      logic          valid;
      hpm_entry_type entry;
   } hpm_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hpm_qstat_type;

endpackage

`default_nettype wire

FILE: design/hpm_front.sv
// Front part: configuration registers, products, sums and classification.
`default_nettype none

module hpm_front import hpm_pkg::*; #(
   parameter int COEF_WIDTH  = 32,
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_in_u,
   input  logic [31:0] req_in_v,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  hpm_qstat_type qstat,
   output hpm_push_type  push
);

   localparam int QB = COORD_WIDTH + 1;
   localparam int RW = MAG_W + QB;

   logic [63:0] pair_ff [4];
   logic [31:0] last_ff;
   logic [1:0]  side_ff;
   logic [31:0] dmin_ff;

   function automatic logic signed [31:0] coef_ext(input logic [31:0] slot);
      logic signed [31:0] r;
      r = 32'(signed'(slot[COEF_WIDTH-1:0]));
      return r;
   endfunction

   function automatic logic signed [31:0] coord_ext(input logic [31:0] raw);
      logic signed [31:0] r;
      r = 32'(signed'(raw[COORD_WIDTH-1:0]));
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff[0] <= '0;
         pair_ff[1] <= '0;
         pair_ff[2] <= '0;
         pair_ff[3] <= '0;
         last_ff    <= '0;
         side_ff    <= SIDE_NOT_READY;
         dmin_ff    <= DMIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAIR_A: pair_ff[0] <= csr_wdata;
            CSR_PAIR_B: pair_ff[1] <= csr_wdata;
            CSR_PAIR_C: pair_ff[2] <= csr_wdata;
            CSR_PAIR_D: pair_ff[3] <= csr_wdata;
            CSR_LAST:   last_ff    <= csr_wdata[31:0];
            CSR_SIDE:   side_ff    <= csr_wdata[1:0];
            CSR_DMIN:   dmin_ff    <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   logic signed [31:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
   assign m0 = coef_ext(pair_ff[0][31:0]);
   assign m1 = coef_ext(pair_ff[0][63:32]);
   assign m2 = coef_ext(pair_ff[1][31:0]);
   assign m3 = coef_ext(pair_ff[1][63:32]);
   assign m4 = coef_ext(pair_ff[2][31:0]);
   assign m5 = coef_ext(pair_ff[2][63:32]);
   assign m6 = coef_ext(pair_ff[3][31:0]);
   assign m7 = coef_ext(pair_ff[3][63:32]);
   assign m8 = coef_ext(last_ff);

   // The whole front moves together while the queue has room.
   logic adv;
   assign adv       = !qstat.full;
   assign req_stall = qstat.full;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [31:0] u1_ff, vv1_ff;
   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [SUM_W-1:0] sx_ff, sy_ff, sw_ff;
   logic [MAG_W-1:0] ax4_ff, ay4_ff, wm4_ff;
   logic negx4_ff, negy4_ff, wneg4_ff;
   hpm_entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   logic signed [SUM_W-1:0] abs_x, abs_y, abs_w;
   assign abs_x = sx_ff[SUM_W-1] ? -sx_ff : sx_ff;
   assign abs_y = sy_ff[SUM_W-1] ? -sy_ff : sy_ff;
   assign abs_w = sw_ff[SUM_W-1] ? -sw_ff : sw_ff;

   logic [NUM_W-1:0] nx5, ny5;
   logic [RW-1:0]    den_sh;
   logic             ovf5, near_zero, wrong_side;
   hpm_status_type   st5;

   assign nx5    = {ax4_ff, {FRAC_SHIFT{1'b0}}};
   assign ny5    = {ay4_ff, {FRAC_SHIFT{1'b0}}};
   assign den_sh = RW'(wm4_ff) << QB;
   // A quotient of more than QB bits can never round into range.
   assign ovf5   = (RW'(nx5) >= den_sh) || (RW'(ny5) >= den_sh);
   assign near_zero  = (wm4_ff == '0) || (wm4_ff < MAG_W'(dmin_ff));
   assign wrong_side = ((side_ff == SIDE_POS) && wneg4_ff) ||
                       ((side_ff == SIDE_NEG) && !wneg4_ff);

   always_comb begin
      priority if (side_ff == SIDE_NOT_READY) begin
         st5 = ST_NOT_READY;
      end else if (near_zero) begin
         st5 = ST_NEAR_ZERO;
      end else if (wrong_side) begin
         st5 = ST_WRONG_SIDE;
      end else if (ovf5) begin
         st5 = ST_RANGE;
      end else begin
         st5 = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff  <= coord_ext(req_in_u);
         vv1_ff <= coord_ext(req_in_v);
         pa_ff  <= m0 * u1_ff;
         pb_ff  <= m1 * vv1_ff;
         pc_ff  <= m3 * u1_ff;
         pd_ff  <= m4 * vv1_ff;
         pe_ff  <= m6 * u1_ff;
         pf_ff  <= m7 * vv1_ff;
         sx_ff  <= SUM_W'(pa_ff) + SUM_W'(pb_ff) + (SUM_W'(m2) <<< COEF_ALIGN);
         sy_ff  <= SUM_W'(pc_ff) + SUM_W'(pd_ff) + (SUM_W'(m5) <<< COEF_ALIGN);
         sw_ff  <= SUM_W'(pe_ff) + SUM_W'(pf_ff) + (SUM_W'(m8) <<< COEF_ALIGN);
         ax4_ff   <= abs_x[MAG_W-1:0];
         ay4_ff   <= abs_y[MAG_W-1:0];
         wm4_ff   <= abs_w[MAG_W-1:0];
         wneg4_ff <= sw_ff[SUM_W-1];
         negx4_ff <= sx_ff[SUM_W-1] ^ sw_ff[SUM_W-1];
         negy4_ff <= sy_ff[SUM_W-1] ^ sw_ff[SUM_W-1];
         ent_ff.n_x    <= nx5;
         ent_ff.n_y    <= ny5;
         ent_ff.d      <= wm4_ff;
         ent_ff.neg_x  <= negx4_ff;
         ent_ff.neg_y  <= negy4_ff;
         ent_ff.status <= st5;
      end
   end

   assign push.valid = v5_ff;
   assign push.entry = ent_ff;

endmodule

`default_nettype wire

FILE: design/hpm_queue.sv
// Short queue between the front and the back.
`default_nettype none

module hpm_queue import hpm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  hpm_push_type  push,
   input  logic          pop,
   output hpm_qstat_type qstat,
   output hpm_entry_type head
);

   hpm_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push = push.valid && !qstat.full;
   assign do_pop  = pop && !qstat.empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/hpm_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module hpm_div_lane import hpm_pkg::*; #(
   parameter int QB = 33
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [MAG_W-1:0] den,
   output logic [QB-1:0]    quo
);

   localparam int RW = MAG_W + QB;

   logic [RW-1:0]    r_ff [QB];
   logic [MAG_W-1:0] d_ff [QB];
   logic [QB-1:0]    q_ff [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= RW'(num);
         d_ff[0] <= den;
         q_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= QB; s++) begin : g_stage
      localparam int BIT = QB - s;
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(d_ff[s-1]) << BIT;
      assign ge  = r_ff[s-1] >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s] <= q_ff[s-1] | (QB'(ge) << BIT);
         end
      end

      if (s < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[s] <= ge ? r_ff[s-1] - dsh : r_ff[s-1];
               d_ff[s] <= d_ff[s-1];
            end
         end
      end
   end

   assign quo = q_ff[QB];

endmodule

`default_nettype wire

FILE: design/hpm_back.sv
// Back part: two divider lanes, rounding, range check and output register.
`default_nettype none

module hpm_back import hpm_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  hpm_qstat_type qstat,
   input  hpm_entry_type head,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_out_x,
   output logic [31:0]   rsp_out_y,
   output logic [2:0]    rsp_map_status
);

   localparam int QB  = COORD_WIDTH + 1;
   localparam int LAT = QB + 1;

   logic adv;
   logic out_v_ff;
   logic [31:0] x_ff, y_ff;
   hpm_status_type st_ff;

   assign adv = !out_v_ff || !rsp_stall;
   assign pop = adv;

   logic [QB-1:0] qx, qy;

   hpm_div_lane #(.QB(QB)) u_lane_x (
      .clock (clock), .en (adv), .num (head.n_x), .den (head.d), .quo (qx)
   );
   hpm_div_lane #(.QB(QB)) u_lane_y (
      .clock (clock), .en (adv), .num (head.n_y), .den (head.d), .quo (qy)
   );

   logic           mv_ff  [LAT];
   hpm_status_type mst_ff [LAT];
   logic           mnx_ff [LAT];
   logic           mny_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            mv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         mv_ff[0] <= !qstat.empty;
         for (int k = 1; k < LAT; k++) begin
            mv_ff[k] <= mv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mst_ff[0] <= head.status;
         mnx_ff[0] <= head.neg_x;
         mny_ff[0] <= head.neg_y;
         for (int k = 1; k < LAT; k++) begin
            mst_ff[k] <= mst_ff[k-1];
            mnx_ff[k] <= mnx_ff[k-1];
            mny_ff[k] <= mny_ff[k-1];
         end
      end
   end

   logic [QB:0]   rx, ry;
   logic [QB-1:0] rndx, rndy, lim_pos, lim_neg, valx, valy;
   logic          exc_x, exc_y;
   logic          negx, negy;
   hpm_status_type st_in;
   logic [31:0]   x_in, y_in;

   assign negx    = mnx_ff[LAT-1];
   assign negy    = mny_ff[LAT-1];
   assign lim_neg = QB'(1) << (COORD_WIDTH - 1);
   assign lim_pos = lim_neg - 1'b1;
   // Round to nearest with ties away from zero on the magnitude.
   assign rx      = (QB+1)'(qx) + 1'b1;
   assign ry      = (QB+1)'(qy) + 1'b1;
   assign rndx    = rx[QB:1];
   assign rndy    = ry[QB:1];
   assign exc_x   = rndx > (negx ? lim_neg : lim_pos);
   assign exc_y   = rndy > (negy ? lim_neg : lim_pos);
   assign valx    = negx ? -rndx : rndx;
   assign valy    = negy ? -rndy : rndy;

   always_comb begin
      priority if (mst_ff[LAT-1] != ST_OK) begin
         st_in = mst_ff[LAT-1];
         x_in  = '0;
         y_in  = '0;
      end else if (exc_x || exc_y) begin
         st_in = ST_RANGE;
         x_in  = '0;
         y_in  = '0;
      end else begin
         st_in = ST_OK;
         x_in  = 32'(signed'(valx[COORD_WIDTH-1:0]));
         y_in  = 32'(signed'(valy[COORD_WIDTH-1:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= mv_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         st_ff <= st_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_x      = x_ff;
   assign rsp_out_y      = y_ff;
   assign rsp_map_status = st_ff;

endmodule

`default_nettype wire

FILE: design/homography_point_mapper_core.sv
// Top level of the homography point mapper.
//
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_in_u, req_in_v
// rsp      out        rsp_valid/stall    rsp_out_x, rsp_out_y, rsp_map_status
// csr      in         csr_valid/ready    csr_index, csr_wdata
//
// One point is accepted and one result delivered per clock when not stalled.
// The divider lanes resolve one quotient bit per pipeline stage.
// Reset clears the control state and loads the register reset values.
// A stalled result holds the back part; the front keeps accepting until the
// four-entry queue between them is full.
`default_nettype none

module homography_point_mapper_core import hpm_pkg::*; #(
   parameter int COEF_WIDTH  = 32,
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_in_u,
   input  logic [31:0] req_in_v,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [2:0]  rsp_map_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   hpm_push_type  push;
   hpm_qstat_type qstat;
   hpm_entry_type head;
   logic          pop;

   hpm_front #(.COEF_WIDTH(COEF_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in_u  (req_in_u),
      .req_in_v  (req_in_v),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .push      (push)
   );

   hpm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   hpm_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_map_status (rsp_map_status)
   );

endmodule

`default_nettype wire

FILE: design/hpm_checker.sv
// Port-level checks of the homography point mapper and their binding.
`default_nettype none

module hpm_checker import hpm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_in_u,
   input logic [31:0] req_in_v,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y,
   input logic [2:0]  rsp_map_status,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [63:0] csr_wdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_open: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) &&
      $stable(rsp_out_y) && $stable(rsp_map_status))
      else $error("stalled result changed");

   a_zero_on_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_map_status != ST_OK) |-> (rsp_out_x == '0) && (rsp_out_y == '0))
      else $error("rejected point carries coordinates");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_map_status <= ST_RANGE)
      else $error("status code out of range");

endmodule

bind homography_point_mapper_core hpm_checker u_hpm_checker (.*);

`default_nettype wire
